FILE: design/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg: shared types and constants for the message dedup cooldown table
// Widths, character codes, table sizing and the table write request.
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

	localparam int TABLE_ENTRIES = 8;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int BYTE_W     = 8;
	localparam int HASH_W     = 32;
	localparam int TIME_W     = 63;
	localparam int COOLDOWN_W = 17;
	localparam int WINDOW_W   = 27;
	localparam int OUT_IDX_W  = 3;

	localparam logic [HASH_W-1:0]     HASH_SEED      = 32'd5381;
	localparam logic [BYTE_W-1:0]     CHAR_TERM      = 8'h00;
	localparam logic [BYTE_W-1:0]     CHAR_RPAREN    = 8'h29;
	localparam logic [BYTE_W-1:0]     CHAR_SPACE     = 8'h20;
	localparam logic [WINDOW_W-1:0]   MS_PER_SECOND  = 27'd1000;
	localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 17'd300;
	localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 27'd300000;

	typedef struct packed {
		logic              en;
		logic              hash_en;
		logic [IDX_W-1:0]  idx;
		logic [HASH_W-1:0] hash;
		logic [TIME_W-1:0] last;
	} tbl_wr_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [TIME_W-1:0] last;
	} tbl_rd_t;

endpackage

`default_nettype wire

FILE: design/mdc_hash.sv
// ----------------------------------------------------------------------------
// mdc_hash: byte hasher with prefix tracking
// Runs the full and content djb2a hashes and detects the ") " prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_hash (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          byte_en,
	input  wire logic                          clear,
	input  wire logic [mdc_pkg::BYTE_W-1:0]    data,
	output logic      [mdc_pkg::HASH_W-1:0]    lookup_hash
);

	logic [mdc_pkg::HASH_W-1:0] full_q;
	logic [mdc_pkg::HASH_W-1:0] content_q;
	logic                       paren_q;
	logic                       prefix_q;
	logic                       passed_q;
	logic [mdc_pkg::HASH_W-1:0] full_next;
	logic [mdc_pkg::HASH_W-1:0] content_next;
	logic [mdc_pkg::HASH_W-1:0] data_ext;
	logic                       restart;
	logic                       first_paren;

	assign data_ext     = {{(mdc_pkg::HASH_W-mdc_pkg::BYTE_W){1'b0}}, data};
	assign full_next    = ((full_q << 5) + full_q) ^ data_ext;
	assign content_next = ((content_q << 5) + content_q) ^ data_ext;
	assign restart      = paren_q && (data == mdc_pkg::CHAR_SPACE);
	assign first_paren  = (data == mdc_pkg::CHAR_RPAREN) && !passed_q;
	assign lookup_hash  = prefix_q ? content_q : full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= mdc_pkg::HASH_SEED;
			content_q <= mdc_pkg::HASH_SEED;
			paren_q   <= 1'b0;
			prefix_q  <= 1'b0;
			passed_q  <= 1'b0;
		end else if (clear) begin
			full_q    <= mdc_pkg::HASH_SEED;
			content_q <= mdc_pkg::HASH_SEED;
			paren_q   <= 1'b0;
			prefix_q  <= 1'b0;
			passed_q  <= 1'b0;
		end else if (byte_en) begin
			full_q <= full_next;
			// The space after the first ')' is not hashed; content restarts.
			if (restart) begin
				prefix_q  <= 1'b1;
				content_q <= mdc_pkg::HASH_SEED;
			end else begin
				content_q <= content_next;
			end
			paren_q <= first_paren;
			if (first_paren) begin
				passed_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/mdc_sub.sv
// ----------------------------------------------------------------------------
// mdc_sub: shared time subtractor
// Computes a - b on 63-bit times with a borrow flag; used for both the
// oldest-entry search and the cooldown check.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_sub (
	input  wire logic [mdc_pkg::TIME_W-1:0] a,
	input  wire logic [mdc_pkg::TIME_W-1:0] b,
	output logic      [mdc_pkg::TIME_W-1:0] diff,
	output logic                            borrow
);

	logic [mdc_pkg::TIME_W:0] full_diff;

	assign full_diff = {1'b0, a} - {1'b0, b};
	assign diff      = full_diff[mdc_pkg::TIME_W-1:0];
	assign borrow    = full_diff[mdc_pkg::TIME_W];

endmodule

`default_nettype wire

FILE: design/mdc_table.sv
// ----------------------------------------------------------------------------
// mdc_table: hash / last-sent table storage
// Entries cleared by reset, one read address and one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [mdc_pkg::IDX_W-1:0]     rd_idx,
	output mdc_pkg::tbl_rd_t                   rd,
	input  wire mdc_pkg::tbl_wr_t              wr
);

	logic [mdc_pkg::HASH_W-1:0] hash_q [mdc_pkg::TABLE_ENTRIES];
	logic [mdc_pkg::TIME_W-1:0] last_q [mdc_pkg::TABLE_ENTRIES];

	assign rd.hash = hash_q[rd_idx];
	assign rd.last = last_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mdc_pkg::TABLE_ENTRIES; i++) begin
				hash_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else if (wr.en) begin
			last_q[wr.idx] <= wr.last;
			if (wr.hash_en) begin
				hash_q[wr.idx] <= wr.hash;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/message_dedup_cooldown_table.sv
// ----------------------------------------------------------------------------
// message_dedup_cooldown_table: repeated-message suppression by hash
// Hashes message bytes and decides on each terminator whether to send.
// ----------------------------------------------------------------------------
// Message bytes are taken one byte per cycle while in_stall is low and hashed
// on the fly. A zero byte ends the message: the block then stalls its input
// while a sequencer walks the table one entry per cycle through a single read
// port, sharing one 63-bit subtractor between the oldest-entry search and the
// cooldown check. The input stays stalled through the scan, which ends early
// on a hit, and through the decision, which also waits while the previous
// result is still held on the output. The result register lets new message
// bytes be accepted while a result waits to be taken. The cooldown window in
// milliseconds is computed once when the register is written.
`default_nettype none

module message_dedup_cooldown_table (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [mdc_pkg::COOLDOWN_W-1:0]    cooldown_seconds,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mdc_pkg::BYTE_W-1:0]        message_byte,
	input  wire logic [mdc_pkg::TIME_W-1:0]        now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   send,
	output logic                                   hit,
	output logic      [mdc_pkg::OUT_IDX_W-1:0]     entry_index,
	output logic      [mdc_pkg::HASH_W-1:0]        message_hash
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	localparam logic [mdc_pkg::IDX_W-1:0] LAST_IDX = mdc_pkg::IDX_W'(mdc_pkg::TABLE_ENTRIES - 1);

	state_t                        state_q;
	logic [mdc_pkg::WINDOW_W-1:0]  window_q;
	logic [mdc_pkg::IDX_W-1:0]     idx_q;
	logic [mdc_pkg::IDX_W-1:0]     pick_q;
	logic [mdc_pkg::TIME_W-1:0]    min_q;
	logic [mdc_pkg::TIME_W-1:0]    last_q;
	logic                          found_q;
	logic [mdc_pkg::HASH_W-1:0]    hash_q;
	logic [mdc_pkg::TIME_W-1:0]    now_q;
	logic                          out_valid_q;
	logic                          send_q;
	logic                          hit_q;
	logic [mdc_pkg::OUT_IDX_W-1:0] entry_index_q;

	logic                          accept;
	logic                          term;
	logic [mdc_pkg::HASH_W-1:0]    lookup_hash;
	mdc_pkg::tbl_rd_t              rd;
	mdc_pkg::tbl_wr_t              wr;
	logic [mdc_pkg::TIME_W-1:0]    sub_a;
	logic [mdc_pkg::TIME_W-1:0]    sub_b;
	logic [mdc_pkg::TIME_W-1:0]    sub_diff;
	logic                          sub_borrow;
	logic                          match;
	logic                          in_window;
	logic                          slot_free;
	logic                          decide_go;
	logic                          send_now;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign term      = accept && (message_byte == mdc_pkg::CHAR_TERM);

	mdc_hash u_hash (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (accept && !term),
		.clear       (term),
		.data        (message_byte),
		.lookup_hash (lookup_hash)
	);

	mdc_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx_q),
		.rd     (rd),
		.wr     (wr)
	);

	// During the scan the subtractor compares an entry time against the
	// oldest seen so far; in the decision cycle it measures elapsed time.
	assign sub_a = (state_q == S_DECIDE) ? now_q  : rd.last;
	assign sub_b = (state_q == S_DECIDE) ? last_q : min_q;

	mdc_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	assign match     = (rd.hash == hash_q);
	assign in_window = sub_borrow ||
		(sub_diff < {{(mdc_pkg::TIME_W-mdc_pkg::WINDOW_W){1'b0}}, window_q});
	assign send_now  = !found_q || !in_window;
	assign slot_free = !out_valid_q || !out_stall;
	assign decide_go = (state_q == S_DECIDE) && slot_free;

	always_comb begin
		wr         = '0;
		wr.idx     = pick_q;
		wr.hash    = hash_q;
		wr.last    = now_q;
		wr.hash_en = !found_q;
		wr.en      = decide_go && send_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= mdc_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= {{(mdc_pkg::WINDOW_W-mdc_pkg::COOLDOWN_W){1'b0}}, cooldown_seconds} *
				mdc_pkg::MS_PER_SECOND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (term) begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match || (idx_q == LAST_IDX)) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (term) begin
			hash_q <= lookup_hash;
			now_q  <= now_ms;
		end
		if (state_q == S_SCAN) begin
			if (match) begin
				found_q <= 1'b1;
				pick_q  <= idx_q;
				last_q  <= rd.last;
			end else begin
				found_q <= 1'b0;
				// Strictly older wins, so ties keep the lower index.
				if ((idx_q == '0) || sub_borrow) begin
					pick_q <= idx_q;
					min_q  <= rd.last;
				end
			end
		end
		if (decide_go) begin
			send_q        <= send_now;
			hit_q         <= found_q;
			entry_index_q <= mdc_pkg::OUT_IDX_W'(pick_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign send         = send_q;
	assign hit          = hit_q;
	assign entry_index  = entry_index_q;

	logic [mdc_pkg::HASH_W-1:0] result_hash_q;

	always_ff @(posedge clk) begin
		if (decide_go) begin
			result_hash_q <= hash_q;
		end
	end

	assign message_hash = result_hash_q;

endmodule

`default_nettype wire
